// ===== hw/rtl/eac_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eac_pkg - shared types and constants of the entropy accumulator
// Fixed-point formats, derived widths, sequencer states and the control
// groups passed between the datapath modules.
// ----------------------------------------------------------------------------
package eac_pkg;

    localparam int PROB_FRAC_BITS = 16;
    localparam int LOG_FRAC_BITS  = 16;
    localparam int MANT_FRAC      = 30;

    localparam int PROB_W  = PROB_FRAC_BITS + 1;
    localparam int MANT_W  = MANT_FRAC + 1;
    localparam int SHIFT_W = $clog2(PROB_FRAC_BITS + 1);
    localparam int MSH_W   = $clog2(MANT_FRAC + 1);
    localparam int NLOG_W  = SHIFT_W + LOG_FRAC_BITS;
    localparam int CNT_W   = $clog2(LOG_FRAC_BITS + 1);
    localparam int PROD_W  = PROB_W + NLOG_W;
    localparam int TERM_W  = PROD_W - PROB_FRAC_BITS;
    localparam int SUM_W   = 24;
    localparam int TALLY_W = 8;

    localparam int IN_TDATA_W  = ((PROB_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((SUM_W + TALLY_W + 7) / 8) * 8;

    typedef logic [PROB_W-1:0]  prob_t;
    typedef logic [NLOG_W-1:0]  nlog_t;
    typedef logic [SUM_W-1:0]   sum_t;
    typedef logic [TALLY_W-1:0] tally_t;

    localparam prob_t PROB_ONE = PROB_W'(1) << PROB_FRAC_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOG,
        ST_MUL,
        ST_ADD,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } log_status_t;

    typedef struct packed {
        logic mul_en;
        logic add_en;
        logic rej_en;
        logic clr;
    } acc_cmd_t;

endpackage

// ===== hw/rtl/shannon_entropy_accumulator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shannon_entropy_accumulator_core - streaming Shannon entropy accumulator
// Sums -p*log2(p) over a distribution of Q1.16 probabilities and emits the
// Q8.16 entropy with the count of zero probabilities on the last beat.
//
// Input channel s_*: one probability per beat, s_tlast marks the last one of
// a distribution. Output channel m_*: one beat per distribution.
// A nonzero probability passes through these steps before the next beat
// can be taken: a load step, 16 squaring steps of the log2 unit (one
// fraction bit per cycle, set by LOG_FRAC_BITS), a log handoff step, a
// multiply and an accumulate step. A zero probability is handled in the
// idle state itself. A last beat adds an emit step, which waits while the
// previous result still sits in the output register. The result beat is
// loaded into the output register by that emit step.
// The result sits in an output register; while the receiver stalls, new
// probabilities keep being taken, and only the next result waits until the
// register is free. Reset clears the sum, the count and the output valid.
// ----------------------------------------------------------------------------
module shannon_entropy_accumulator_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [eac_pkg::IN_TDATA_W-1:0]  s_tdata,   // probability[16:0], zero pad
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [eac_pkg::OUT_TDATA_W-1:0] m_tdata    // entropy_bits[23:0], rejected_count[31:24]
);
    import eac_pkg::*;

    state_t      state_reg, state_next;
    prob_t       p_reg, p_next;
    logic        last_reg, last_next;
    logic        out_valid_reg, out_valid_next;
    logic [SUM_W+TALLY_W-1:0] out_data_reg, out_data_next;

    prob_t       p_in;
    logic        accept;
    logic        out_load;
    logic        log_start;
    log_status_t log_stat;
    nlog_t       nlog;
    acc_cmd_t    cmd;
    sum_t        sum;
    tally_t      tally;

    // values above one count as exactly one
    assign p_in   = (s_tdata[PROB_W-1:0] > PROB_ONE) ? PROB_ONE : s_tdata[PROB_W-1:0];
    assign accept = s_tvalid && s_tready;

    eac_log2 u_log2 (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (log_start),
        .p      (p_in),
        .nlog   (nlog),
        .status (log_stat)
    );

    eac_accum u_accum (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .p     (p_reg),
        .nlog  (nlog),
        .sum   (sum),
        .tally (tally)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (p_in == '0)
                    begin
                        state_next = s_tlast ? ST_EMIT : ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_LOG;
                    end
                end
            end
            ST_LOG:
            begin
                if (log_stat.done)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                state_next = last_reg ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        s_tready   = 1'b0;
        log_start  = 1'b0;
        out_load   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready   = 1'b1;
                log_start  = accept && (p_in != '0);
                cmd.rej_en = accept && (p_in == '0);
            end
            ST_LOG:
            begin
            end
            ST_MUL:
            begin
                cmd.mul_en = 1'b1;
            end
            ST_ADD:
            begin
                cmd.add_en = 1'b1;
            end
            ST_EMIT:
            begin
                out_load = !out_valid_reg || m_tready;
                cmd.clr  = out_load;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        p_next         = p_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (accept)
        begin
            p_next    = p_in;
            last_next = s_tlast;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {tally, sum};
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg        <= p_next;
        last_reg     <= last_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(out_data_reg);

    // the log unit only runs while the sequencer waits for it
    a_log_in_log_state: assert property (@(posedge clk) disable iff (!rst_n)
        (log_stat.busy || log_stat.done) |-> (state_reg == ST_LOG))
        else $error("log unit active outside the log state");

    // loading a result clears the accumulators and raises the output beat
    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (sum == '0) && (tally == '0) && m_tvalid)
        else $error("accumulators not cleared after result load");

    // a zero probability that is not last leaves the sequencer in idle
    a_zero_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (p_in == '0) && !s_tlast) |=> (state_reg == ST_IDLE))
        else $error("zero probability did not return to idle");

    // a nonzero probability reaches the multiply step in the cycle after log done
    a_done_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
        log_stat.done |=> (state_reg == ST_MUL))
        else $error("log result not handed to the multiply step");

endmodule

// ===== hw/rtl/eac_log2.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eac_log2 - bit-serial negated log2 unit
// Normalizes the probability to a mantissa in [1,2), then squares it once
// per cycle, shifting one fraction bit of the logarithm in per step.
// ----------------------------------------------------------------------------
module eac_log2 (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  eac_pkg::prob_t       p,
    output eac_pkg::nlog_t       nlog,
    output eac_pkg::log_status_t status
);
    import eac_pkg::*;

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [MANT_W-1:0]        mant_reg, mant_next;
    logic [SHIFT_W-1:0]       int_reg, int_next;
    logic [LOG_FRAC_BITS-1:0] frac_reg, frac_next;

    logic [SHIFT_W-1:0]       msb;
    logic [MSH_W-1:0]         mant_sh;
    logic [2*MANT_W-1:0]      square;
    logic [MANT_W:0]          sq_hi;
    logic                     last_step;

    // leading-one position of the incoming probability
    always_comb
    begin
        msb = '0;
        for (int i = 0; i < PROB_W; i++)
        begin
            if (p[i])
            begin
                msb = SHIFT_W'(i);
            end
        end
        mant_sh = MSH_W'(MANT_FRAC) - MSH_W'(msb);
    end

    assign square    = mant_reg * mant_reg;
    assign sq_hi     = square[2*MANT_W-1:MANT_FRAC];
    assign last_step = busy_reg && (cnt_reg == CNT_W'(LOG_FRAC_BITS - 1));

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        mant_next = mant_reg;
        int_next  = int_reg;
        frac_next = frac_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            mant_next = MANT_W'(p) << mant_sh;
            int_next  = SHIFT_W'(PROB_FRAC_BITS) - msb;
            frac_next = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
            // square at or above 2.0 gives a one bit and is halved
            if (sq_hi[MANT_W])
            begin
                mant_next = sq_hi[MANT_W:1];
                frac_next = {frac_reg[LOG_FRAC_BITS-2:0], 1'b1};
            end
            else
            begin
                mant_next = sq_hi[MANT_W-1:0];
                frac_next = {frac_reg[LOG_FRAC_BITS-2:0], 1'b0};
            end
            if (last_step)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mant_reg <= mant_next;
        int_reg  <= int_next;
        frac_reg <= frac_next;
    end

    assign nlog        = {int_reg, {LOG_FRAC_BITS{1'b0}}} - NLOG_W'(frac_reg);
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ===== hw/rtl/eac_accum.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eac_accum - term product and saturating accumulators
// Forms p * -log2(p), adds it into the entropy sum with saturation and
// keeps the saturating count of rejected zero probabilities.
// ----------------------------------------------------------------------------
module eac_accum (
    input  logic              clk,
    input  logic              rst_n,
    input  eac_pkg::acc_cmd_t cmd,
    input  eac_pkg::prob_t    p,
    input  eac_pkg::nlog_t    nlog,
    output eac_pkg::sum_t     sum,
    output eac_pkg::tally_t   tally
);
    import eac_pkg::*;

    logic [TERM_W-1:0] term_reg, term_next;
    sum_t              sum_reg, sum_next;
    tally_t            tally_reg, tally_next;
    logic [PROD_W-1:0] prod;
    logic [SUM_W:0]    sum_wide;

    assign prod     = PROD_W'(p) * PROD_W'(nlog);
    assign sum_wide = (SUM_W+1)'(sum_reg) + (SUM_W+1)'(term_reg);

    always_comb
    begin
        term_next  = term_reg;
        sum_next   = sum_reg;
        tally_next = tally_reg;
        if (cmd.mul_en)
        begin
            term_next = prod[PROD_W-1:PROB_FRAC_BITS];
        end
        if (cmd.clr)
        begin
            sum_next   = '0;
            tally_next = '0;
        end
        else
        begin
            if (cmd.add_en)
            begin
                sum_next = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
            end
            if (cmd.rej_en && (tally_reg != '1))
            begin
                tally_next = tally_reg + TALLY_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            tally_reg <= '0;
        end
        else
        begin
            sum_reg   <= sum_next;
            tally_reg <= tally_next;
        end
    end

    always_ff @(posedge clk)
    begin
        term_reg <= term_next;
    end

    assign sum   = sum_reg;
    assign tally = tally_reg;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - stream-level check of shannon_entropy_accumulator_core
// Feeds probability beats through the s_* channel in random bursts: first a
// table of corner cases, then random distributions. A bit-exact model of the
// -p*log2(p) sum, or a typed table row, predicts each m_* result beat; it is
// compared field by field. The receiver stalls randomly, with one long hold-off.
// ----------------------------------------------------------------------------
module testbench;

    import eac_pkg::*;

    localparam int RANDOM_ITEMS   = 400;
    localparam int HOLDOFF_CYCLES = 800;
    localparam int CYCLE_LIMIT    = 800000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int NUM_ROWS       = 20;

    typedef struct packed {
        prob_t      prob;
        logic       last;
        logic [9:0] reps;
        logic       typed;
        sum_t       ent;
        tally_t     rej;
    } stim_row_t;

    typedef struct packed {
        sum_t   ent;
        tally_t rej;
    } entropy_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;   // probability[16:0], zero pad
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;   // entropy_bits[23:0], rejected_count[31:24]

    // typed expectation riding along with the beat it belongs to
    logic                   beat_typed;
    sum_t                   beat_ent;
    tally_t                 beat_rej;

    sum_t                   entropy_acc;
    tally_t                 zero_tally;
    entropy_result_t        expected_q[$];
    entropy_result_t        exp_res;
    prob_t                  beat_p;
    logic [63:0]            term_w;
    logic [63:0]            sum_w;

    int                     error_count = 0;
    int                     results_seen = 0;
    int                     cycle_count = 0;
    int                     burst_left = 0;
    stim_row_t              directed_rows [0:NUM_ROWS-1];

    shannon_entropy_accumulator_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // -log2(p) with LOG_FRAC_BITS fraction bits, for 0 < p <= 1.0
    function automatic logic [63:0] neg_log2_fixed(input prob_t p);
        int          msb;
        logic [63:0] mant;
        logic [63:0] frac;
        logic [63:0] two;
        msb  = 0;
        frac = '0;
        two  = 64'd2 << MANT_FRAC;
        for (int i = 0; i <= PROB_FRAC_BITS; i++)
        begin
            if (p[i])
                msb = i;
        end
        mant = 64'(p) << (MANT_FRAC - msb);
        for (int i = 0; i < LOG_FRAC_BITS; i++)
        begin
            mant = (mant * mant) >> MANT_FRAC;
            frac = frac << 1;
            if (mant >= two)
            begin
                frac = frac | 64'd1;
                mant = mant >> 1;
            end
        end
        return (64'(PROB_FRAC_BITS - msb) << LOG_FRAC_BITS) - frac;
    endfunction

    // input side updates the running sum, output side checks result beats
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                beat_p = s_tdata[PROB_W-1:0];
                if (beat_p > PROB_ONE)
                    beat_p = PROB_ONE;
                if (beat_p == '0)
                begin
                    if (zero_tally != '1)
                        zero_tally = zero_tally + 1'b1;
                end
                else
                begin
                    term_w = (64'(beat_p) * neg_log2_fixed(beat_p)) >> PROB_FRAC_BITS;
                    sum_w  = 64'(entropy_acc) + term_w;
                    entropy_acc = (sum_w > 64'({SUM_W{1'b1}})) ? '1 : sum_t'(sum_w);
                end
                if (s_tlast)
                begin
                    exp_res.ent = beat_typed ? beat_ent : entropy_acc;
                    exp_res.rej = beat_typed ? beat_rej : zero_tally;
                    expected_q.push_back(exp_res);
                    entropy_acc = '0;
                    zero_tally  = '0;
                end
            end
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result beat, got entropy %0d rejected %0d",
                             $time, m_tdata[SUM_W-1:0], m_tdata[SUM_W+TALLY_W-1:SUM_W]);
                    error_count++;
                end
                else
                begin
                    exp_res = expected_q.pop_front();
                    if (m_tdata[SUM_W-1:0] !== exp_res.ent)
                    begin
                        $display("%0t: entropy_bits mismatch, expected %0d, got %0d",
                                 $time, exp_res.ent, m_tdata[SUM_W-1:0]);
                        error_count++;
                    end
                    if (m_tdata[SUM_W+TALLY_W-1:SUM_W] !== exp_res.rej)
                    begin
                        $display("%0t: rejected_count mismatch, expected %0d, got %0d",
                                 $time, exp_res.rej, m_tdata[SUM_W+TALLY_W-1:SUM_W]);
                        error_count++;
                    end
                end
            end
        end
    end

    task automatic send_beat(input prob_t p, input logic lastf, input logic typed,
                             input sum_t ent, input tally_t rej);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid   <= 1'b1;
        s_tdata    <= IN_TDATA_W'(p);
        s_tlast    <= lastf;
        beat_typed <= typed;
        beat_ent   <= ent;
        beat_rej   <= rej;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // stop offering beats until every pending result has come out
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    // receiver: ready stretches, random stall patterns, one long hold-off
    initial
    begin
        logic [31:0] pat;
        bit          holdoff_done;
        holdoff_done = 0;
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!holdoff_done && results_seen >= 20)
            begin
                holdoff_done = 1;
                m_tready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge clk);
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        m_tready <= 1'b1;
                        repeat ($urandom_range(20, 200)) @(posedge clk);
                    end
                    3:
                    begin
                        m_tready <= 1'b0;
                        repeat ($urandom_range(1, 12)) @(posedge clk);
                    end
                    default:
                    begin
                        pat = $urandom;
                        for (int k = 0; k < 64; k++)
                        begin
                            m_tready <= pat[k % 32];
                            @(posedge clk);
                        end
                    end
                endcase
            end
        end
    end

    initial
    begin
        prob_t       p;
        logic        lastf;
        int          items_sent;
        int          len;
        int          remaining;
        bit          well_formed;
        bit          paused;
        int unsigned reps;

        rst_n       <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tlast     <= 1'b0;
        beat_typed  <= 1'b0;
        beat_ent    <= '0;
        beat_rej    <= '0;
        entropy_acc = '0;
        zero_tally  = '0;

        //                  prob     last  reps    typed entropy        rejected
        directed_rows[0]  = '{17'd65536,  1'b1, 10'd1,   1'b1, 24'd0,        8'd0};
        directed_rows[1]  = '{17'd0,      1'b1, 10'd1,   1'b1, 24'd0,        8'd1};
        directed_rows[2]  = '{17'd131071, 1'b1, 10'd1,   1'b1, 24'd0,        8'd0};
        directed_rows[3]  = '{17'd32768,  1'b1, 10'd1,   1'b1, 24'd32768,    8'd0};
        directed_rows[4]  = '{17'd16384,  1'b0, 10'd3,   1'b0, 24'd0,        8'd0};
        directed_rows[5]  = '{17'd16384,  1'b1, 10'd1,   1'b1, 24'd131072,   8'd0};
        directed_rows[6]  = '{17'd1,      1'b0, 10'd1,   1'b0, 24'd0,        8'd0};
        directed_rows[7]  = '{17'd65535,  1'b0, 10'd1,   1'b0, 24'd0,        8'd0};
        directed_rows[8]  = '{17'd0,      1'b0, 10'd1,   1'b0, 24'd0,        8'd0};
        directed_rows[9]  = '{17'd98304,  1'b0, 10'd1,   1'b0, 24'd0,        8'd0};
        directed_rows[10] = '{17'd2,      1'b1, 10'd1,   1'b0, 24'd0,        8'd0};
        directed_rows[11] = '{17'd0,      1'b0, 10'd300, 1'b0, 24'd0,        8'd0};
        directed_rows[12] = '{17'd0,      1'b1, 10'd1,   1'b1, 24'd0,        8'd255};
        directed_rows[13] = '{17'd24109,  1'b0, 10'd500, 1'b0, 24'd0,        8'd0};
        directed_rows[14] = '{17'd24109,  1'b1, 10'd1,   1'b1, 24'hFFFFFF,   8'd0};
        directed_rows[15] = '{17'd24109,  1'b0, 10'd600, 1'b0, 24'd0,        8'd0};
        directed_rows[16] = '{17'd0,      1'b0, 10'd260, 1'b0, 24'd0,        8'd0};
        directed_rows[17] = '{17'd65535,  1'b1, 10'd1,   1'b1, 24'hFFFFFF,   8'd255};
        directed_rows[18] = '{17'd43690,  1'b0, 10'd1,   1'b0, 24'd0,        8'd0};
        directed_rows[19] = '{17'd21846,  1'b1, 10'd1,   1'b0, 24'd0,        8'd0};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < NUM_ROWS; r++)
        begin
            reps = directed_rows[r].reps;
            for (int unsigned k = 0; k < reps; k++)
            begin
                lastf = directed_rows[r].last && (k == reps - 1);
                send_beat(directed_rows[r].prob, lastf, directed_rows[r].typed && lastf,
                          directed_rows[r].ent, directed_rows[r].rej);
            end
        end
        drain_results();

        // random distributions: mostly summing to one, the rest raw noise
        items_sent = 0;
        paused     = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            len = ($urandom_range(0, 39) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 12);
            well_formed = ($urandom_range(0, 9) < 7);
            remaining   = int'(PROB_ONE);
            for (int k = 0; k < len; k++)
            begin
                lastf = (k == len - 1);
                if (well_formed)
                begin
                    p = lastf ? prob_t'(remaining) : prob_t'($urandom_range(0, remaining));
                    remaining = remaining - int'(p);
                end
                else
                begin
                    case ($urandom_range(0, 7))
                        0:       p = '0;
                        1:       p = PROB_ONE;
                        2:       p = prob_t'($urandom_range(65537, 131071));
                        default: p = prob_t'($urandom_range(1, 65535));
                    endcase
                end
                send_beat(p, lastf, 1'b0, '0, '0);
                items_sent++;
            end
            if (!paused && items_sent >= RANDOM_ITEMS / 2)
            begin
                paused = 1;
                drain_results();
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/eac_pkg.sv
hw/rtl/eac_log2.sv
hw/rtl/eac_accum.sv
hw/rtl/shannon_entropy_accumulator_core.sv
sim/testbench.sv
